// ===== hdl/are_pkg.sv =====
`timescale 1ns / 1ps
package are_pkg;
    localparam int TABLE_ENTRIES_DEF = 257;
    localparam int FREQ_W = 17;
    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] RANGE_RESET = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] RANGE_BOT = 32'h0001_0000;
    localparam logic [FREQ_W-1:0] TOTAL_LIMIT = 17'h0ffff;
    localparam logic [WORD_W-1:0] CARRY_MASK = 32'h00ff_0000;
    localparam logic [2:0] MAX_EMIT = 3'd4;
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;
endpackage

// ===== hdl/are_if.sv =====
`timescale 1ns / 1ps
interface are_in_if;
    logic valid;
    logic ready;
    logic action;
    logic [7:0] symbol;
    modport source (output valid, action, symbol, input ready);
    modport sink (input valid, action, symbol, output ready);
endinterface

interface are_out_if;
    logic valid;
    logic ready;
    logic [7:0] out_byte;
    logic last;
    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

// ===== hdl/adaptive_range_encoder_unit.sv =====
`timescale 1ns / 1ps
// Adaptive order-0 range encoder for bytes. One request is taken at a time:
// an encode request reads the symbol bounds and total from the frequency
// table (a single-port memory of TABLE_ENTRIES words), divides range by the
// total in a restoring divider (one quotient bit per cycle), multiplies,
// then walks the table once to increment every entry above the symbol and,
// if the total passes 0xffff, walks it again to halve it. Then up to four
// bytes of low are emitted, one per cycle when the output is taken. A flush
// request costs four output handshakes. After reset the table is initialized
// by a sweep over all TABLE_ENTRIES entries, during which no request is
// accepted.
module adaptive_range_encoder_unit #(
    parameter int TABLE_ENTRIES = are_pkg::TABLE_ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    are_in_if.sink   in_ch,
    are_out_if.source out_ch
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int FW = are_pkg::FREQ_W;
    localparam int WW = are_pkg::WORD_W;
    localparam logic [IW-1:0] TOT_IDX = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_RD_LO, S_RD_HI, S_RD_TOT, S_WAIT_TOT, S_DIV,
        S_MUL_LO, S_MUL_RG, S_INC_RD, S_INC_WR, S_HLV_RD, S_HLV_WR,
        S_EMIT, S_FLUSH
    } state_t;

    state_t state_reg;
    logic [FW-1:0] mem [TABLE_ENTRIES];
    logic [FW-1:0] rdata_reg;
    logic [IW-1:0] idx_reg;
    logic [WW-1:0] low_reg, range_reg;
    logic [WW-1:0] quo_reg, rem_reg, div_reg;
    logic [5:0] cnt_reg;
    logic [FW-1:0] lo_reg, hi_reg, prev_reg;
    logic [7:0] sym_reg;
    logic [2:0] nout_reg;

    logic we;
    logic [IW-1:0] addr;
    logic [FW-1:0] wdata;
    logic [WW:0] rem_sh;
    logic [FW-1:0] hv;
    logic [WW-1:0] low16, rng_clamp;
    logic out_fire, emit_more;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_EMIT) || (state_reg == S_FLUSH);
    assign out_ch.out_byte = low_reg[WW-1 -: 8];
    assign out_fire = out_ch.valid && out_ch.ready;
    assign rem_sh = {rem_reg, quo_reg[WW-1]};
    assign hv = rdata_reg >> 1;
    assign low16 = {16'd0, low_reg[15:0]};
    assign rng_clamp = ((low_reg & are_pkg::CARRY_MASK) == are_pkg::CARRY_MASK
        && (range_reg + low16) >= are_pkg::RANGE_BOT)
        ? (are_pkg::RANGE_BOT - low16) : range_reg;
    assign emit_more = ((rng_clamp << 8) < are_pkg::RANGE_BOT)
        && (nout_reg + 3'd1 < are_pkg::MAX_EMIT);
    assign out_ch.last = (state_reg == S_FLUSH) ? (nout_reg == 3'd3) : !emit_more;

    always_comb
    begin
        we = 1'b0;
        addr = idx_reg;
        wdata = rdata_reg + FW'(1);
        unique case (state_reg)
            S_INIT:
            begin
                we = 1'b1;
                wdata = FW'(idx_reg);
            end
            S_INC_WR: we = 1'b1;
            S_HLV_WR:
            begin
                we = 1'b1;
                wdata = (idx_reg != '0 && hv <= prev_reg) ? prev_reg + FW'(1) : hv;
            end
            S_IDLE: addr = IW'(in_ch.symbol);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg <= '0;
            low_reg <= '0;
            range_reg <= are_pkg::RANGE_RESET;
            quo_reg <= '0;
            rem_reg <= '0;
            div_reg <= '0;
            cnt_reg <= '0;
            lo_reg <= '0;
            hi_reg <= '0;
            prev_reg <= '0;
            sym_reg <= '0;
            nout_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    if (idx_reg == TOT_IDX)
                    begin
                        idx_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                S_IDLE:
                begin
                    nout_reg <= '0;
                    if (in_ch.valid)
                    begin
                        sym_reg <= in_ch.symbol;
                        if (in_ch.action == are_pkg::ACT_FLUSH)
                            state_reg <= S_FLUSH;
                        else
                        begin
                            idx_reg <= IW'(in_ch.symbol) + IW'(1);
                            state_reg <= S_RD_LO;
                        end
                    end
                end
                S_RD_LO:
                begin
                    lo_reg <= rdata_reg;
                    idx_reg <= TOT_IDX;
                    state_reg <= S_RD_HI;
                end
                S_RD_HI:
                begin
                    hi_reg <= rdata_reg;
                    state_reg <= S_RD_TOT;
                end
                S_RD_TOT: state_reg <= S_WAIT_TOT;
                S_WAIT_TOT:
                begin
                    div_reg <= (rdata_reg == '0) ? 32'd1 : WW'(rdata_reg);
                    quo_reg <= range_reg;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (rem_sh >= {1'b0, div_reg})
                    begin
                        rem_reg <= WW'(rem_sh - {1'b0, div_reg});
                        quo_reg <= {quo_reg[WW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[WW-1:0];
                        quo_reg <= {quo_reg[WW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(WW - 1))
                        state_reg <= S_MUL_LO;
                end
                S_MUL_LO:
                begin
                    low_reg <= low_reg + WW'(quo_reg * WW'(lo_reg));
                    state_reg <= S_MUL_RG;
                end
                S_MUL_RG:
                begin
                    range_reg <= WW'(quo_reg * WW'(hi_reg - lo_reg));
                    idx_reg <= IW'(sym_reg) + IW'(1);
                    state_reg <= S_INC_RD;
                end
                S_INC_RD: state_reg <= S_INC_WR;
                S_INC_WR:
                begin
                    if (idx_reg == TOT_IDX)
                    begin
                        idx_reg <= '0;
                        if (rdata_reg + FW'(1) > are_pkg::TOTAL_LIMIT)
                            state_reg <= S_HLV_RD;
                        else if (range_reg >= are_pkg::RANGE_BOT)
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                        state_reg <= S_INC_RD;
                    end
                end
                S_HLV_RD: state_reg <= S_HLV_WR;
                S_HLV_WR:
                begin
                    prev_reg <= (idx_reg != '0 && hv <= prev_reg) ? prev_reg + FW'(1) : hv;
                    if (idx_reg == TOT_IDX)
                    begin
                        idx_reg <= '0;
                        state_reg <= (range_reg >= are_pkg::RANGE_BOT) ? S_IDLE : S_EMIT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                        state_reg <= S_HLV_RD;
                    end
                end
                S_EMIT:
                begin
                    if (out_fire)
                    begin
                        low_reg <= low_reg << 8;
                        range_reg <= rng_clamp << 8;
                        nout_reg <= nout_reg + 3'd1;
                        if (!emit_more)
                            state_reg <= S_IDLE;
                    end
                end
                S_FLUSH:
                begin
                    if (out_fire)
                    begin
                        low_reg <= low_reg << 8;
                        nout_reg <= nout_reg + 3'd1;
                        if (nout_reg == 3'd3)
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("request accepted while output pending");
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> nout_reg < are_pkg::MAX_EMIT)
        else $error("more than four bytes emitted");
    a_flush_low: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && out_fire && out_ch.last) |=> low_reg == '0)
        else $error("low not cleared by flush");
endmodule
